@@ src/trp_pkg.sv @@
// Shared types and constants for the TLV response parser.
package trp_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned WORD_W         = 16;
    localparam int unsigned STATUS_W       = 3;
    localparam int unsigned HDR_POS_W      = 3;
    localparam int unsigned HEADER_BYTES   = 7;
    localparam int unsigned RESULT_BYTES   = 4;
    localparam logic [BYTE_W-1:0] RESULT_TYPE = 8'h02;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_RECHEAD = 2'd1,
        PH_VALUE   = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_WRONG_TXN = 3'd3,
        ST_NO_RESULT = 3'd4
    } t_status;

endpackage

@@ src/trp_in_if.sv @@
// Byte input channel of the TLV response parser.
interface trp_in_if import trp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source(output valid, data_byte, last_byte, input ready);
    modport sink(input valid, data_byte, last_byte, output ready);
endinterface

@@ src/trp_out_if.sv @@
// Status output channel of the TLV response parser.
interface trp_out_if import trp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   result_code;
    logic [WORD_W-1:0]   error_code;

    modport source(output valid, status, result_code, error_code, input ready);
    modport sink(input valid, status, result_code, error_code, output ready);
endinterface

@@ src/tlv_response_parser_unit.sv @@
// TLV response parser: walks a framed response one byte per transfer and reports a status.
//
// The input channel carries one message byte per transfer with a flag on the final byte.
// Each message has a 7-byte header whose bytes 1 and 2 hold a little-endian transaction
// word, compared with the configured expected transaction. Type/length/value records
// follow; the first type 2 record of length four or more supplies a result word and an
// error word. The output channel carries one status transfer per message, produced for
// the final byte only.
// Bytes enter an input register and are parsed from there into the parser state registers.
// The status of a message is written into the output register when its final byte is parsed.
// One byte is taken per cycle while no final byte waits on a full output register.
// A stalled output blocks only a final byte; ordinary bytes keep flowing while a status
// waits in the output register.
// Reset clears the message state, the valid flags of both channel registers and the expected transaction.
// The configuration register is written through i_cfg_we and i_cfg_data.
module tlv_response_parser_unit import trp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    trp_in_if.sink            i_in,
    trp_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_data
);

    logic [WORD_W-1:0]    r_exp_txn;

    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_byte;
    logic                 r_last;

    t_phase               r_phase, n_phase;
    logic [HDR_POS_W-1:0] r_hdr_pos, n_hdr_pos;
    logic [BYTE_W-1:0]    r_txn_low, n_txn_low;
    logic                 r_txn_match, n_txn_match;
    logic [BYTE_W-1:0]    r_rec_type, n_rec_type;
    logic [WORD_W-1:0]    r_rec_len, n_rec_len;
    logic [WORD_W-1:0]    r_rec_off, n_rec_off;
    logic                 r_found, n_found;
    logic [WORD_W-1:0]    r_res, n_res;
    logic [WORD_W-1:0]    r_err, n_err;

    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic [WORD_W-1:0]    r_out_res, n_out_res;
    logic [WORD_W-1:0]    r_out_err, n_out_err;

    logic                 out_free;
    logic                 proc;
    logic                 wanted;
    logic [WORD_W-1:0]    new_len;

    assign out_free   = !r_out_valid || o_out.ready;
    assign proc       = r_in_valid && (!r_last || out_free);
    assign i_in.ready = !r_in_valid || proc;

    assign wanted  = (r_rec_type == RESULT_TYPE) && (r_rec_len >= WORD_W'(RESULT_BYTES));
    assign new_len = {r_byte, r_rec_len[BYTE_W-1:0]};

    always_comb begin
        n_phase     = r_phase;
        n_hdr_pos   = r_hdr_pos;
        n_txn_low   = r_txn_low;
        n_txn_match = r_txn_match;
        n_rec_type  = r_rec_type;
        n_rec_len   = r_rec_len;
        n_rec_off   = r_rec_off;
        n_found     = r_found;
        n_res       = r_res;
        n_err       = r_err;
        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_pos == HDR_POS_W'(1)) begin
                    n_txn_low = r_byte;
                end else if (r_hdr_pos == HDR_POS_W'(2)) begin
                    n_txn_match = ({r_byte, r_txn_low} == r_exp_txn);
                end
                if (r_hdr_pos >= HDR_POS_W'(HEADER_BYTES - 1)) begin
                    n_phase   = PH_RECHEAD;
                    n_rec_off = '0;
                end else begin
                    n_hdr_pos = r_hdr_pos + HDR_POS_W'(1);
                end
            end
            PH_RECHEAD: begin
                case (r_rec_off[1:0])
                    2'd0: begin
                        n_rec_type = r_byte;
                        n_rec_len  = '0;
                        n_rec_off  = WORD_W'(1);
                    end
                    2'd1: begin
                        n_rec_len = {{(WORD_W-BYTE_W){1'b0}}, r_byte};
                        n_rec_off = WORD_W'(2);
                    end
                    default: begin
                        n_rec_len = new_len;
                        n_rec_off = '0;
                        if (new_len != '0) begin
                            n_phase = PH_VALUE;
                        end
                    end
                endcase
            end
            PH_VALUE: begin
                if (wanted) begin
                    case (r_rec_off[1:0])
                        2'd0:    n_res = {{(WORD_W-BYTE_W){1'b0}}, r_byte};
                        2'd1:    n_res = {r_byte, r_res[BYTE_W-1:0]};
                        2'd2:    n_err = {{(WORD_W-BYTE_W){1'b0}}, r_byte};
                        default: n_err = {r_byte, r_err[BYTE_W-1:0]};
                    endcase
                    if (r_rec_off >= WORD_W'(RESULT_BYTES - 1)) begin
                        n_found = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_rec_off = r_rec_off + WORD_W'(1);
                    end
                end else begin
                    if (({1'b0, r_rec_off} + (WORD_W+1)'(1)) >= {1'b0, r_rec_len}) begin
                        n_phase   = PH_RECHEAD;
                        n_rec_off = '0;
                    end else begin
                        n_rec_off = r_rec_off + WORD_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_res = '0;
        n_out_err = '0;
        if (n_phase == PH_HEADER) begin
            n_status = ST_SHORT;
        end else if (!n_txn_match) begin
            n_status = ST_WRONG_TXN;
        end else if (n_found) begin
            n_out_res = n_res;
            n_out_err = n_err;
            n_status  = (n_res == '0) ? ST_ACCEPTED : ST_REJECTED;
        end else begin
            n_status = ST_NO_RESULT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_txn <= '0;
        end else if (i_cfg_we) begin
            r_exp_txn <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_last)) begin
            r_phase     <= PH_HEADER;
            r_hdr_pos   <= '0;
            r_txn_low   <= '0;
            r_txn_match <= 1'b0;
            r_rec_type  <= '0;
            r_rec_len   <= '0;
            r_rec_off   <= '0;
            r_found     <= 1'b0;
            r_res       <= '0;
            r_err       <= '0;
        end else if (proc) begin
            r_phase     <= n_phase;
            r_hdr_pos   <= n_hdr_pos;
            r_txn_low   <= n_txn_low;
            r_txn_match <= n_txn_match;
            r_rec_type  <= n_rec_type;
            r_rec_len   <= n_rec_len;
            r_rec_off   <= n_rec_off;
            r_found     <= n_found;
            r_res       <= n_res;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_last) begin
            r_status  <= n_status;
            r_out_res <= n_out_res;
            r_out_err <= n_out_err;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.result_code = r_out_res;
    assign o_out.error_code  = r_out_err;

    a_no_code_without_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_ACCEPTED && r_status != ST_REJECTED)
        |-> (r_out_res == '0 && r_out_err == '0))
        else $error("Result words are nonzero on a status without a result record.");

    a_accept_matches_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_status == ST_ACCEPTED) == (r_out_res == '0)
                         || r_status == ST_REJECTED
                         || r_status == ST_SHORT
                         || r_status == ST_WRONG_TXN
                         || r_status == ST_NO_RESULT)
                        && !(r_status == ST_REJECTED && r_out_res == '0))
        else $error("Accepted or rejected status disagrees with the result word.");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_last) |=> (r_phase == PH_HEADER && r_hdr_pos == '0 && !r_found))
        else $error("Message state was not cleared after the final byte.");

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_last && r_out_valid))
        else $error("Input stalled without a final byte waiting on a full output.");

    a_found_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_phase == PH_DONE))
        else $error("Result record flagged outside the done phase.");

endmodule
